// ----- design/stl_pkg.sv -----
// Shared types and constants for the script token lexer.
package stl_pkg;

  // Lexer state while a token is open
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_ZERO,
    MODE_HEX,
    MODE_NUM,
    MODE_DOT,
    MODE_CHAR,
    MODE_STRING
  } lex_mode_t;

  localparam logic [2:0] KIND_END    = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_HEX    = 3'd2;
  localparam logic [2:0] KIND_NUM    = 3'd3;
  localparam logic [2:0] KIND_REAL   = 3'd4;
  localparam logic [2:0] KIND_CHAR   = 3'd5;
  localparam logic [2:0] KIND_STRING = 3'd6;
  localparam logic [2:0] KIND_OTHER  = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Offsets that map a letter to its digit value 10..35
  localparam logic [7:0] LOWER_BIAS = 8'h57;
  localparam logic [7:0] UPPER_BIAS = 8'h37;

  localparam int FIELD_W     = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One classified input character
  typedef struct packed {
    logic [7:0] ch;
    logic       nul;
    logic       blank;
    logic       digit;
    logic       alpha;
    logic       word;
    logic       ident_start;
    logic       dot;
    logic       squote;
    logic       dquote;
    logic       bslash;
    logic       letter_x;
    logic [5:0] hexval;
  } char_class_t;

  // One result transaction
  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        value;
    logic [FIELD_W-1:0] spaces;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } token_t;

endpackage

// ----- design/stl_front.sv -----
// Front end: accepts characters and decodes their classes.
module stl_front
  import stl_pkg::*;
(
  input  logic        [7:0] ch,
  input  logic              ch_valid,
  output logic              ch_stall,
  input  logic              q_full,
  output logic              push,
  output char_class_t       cls
);

  logic [7:0] off;
  logic       lower;
  logic       upper;

  assign ch_stall = q_full;
  assign push     = ch_valid && !q_full;

  always_comb begin
    lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
    upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
    cls.ch          = ch;
    cls.nul         = (ch == CH_NUL);
    cls.blank       = (ch == CH_SPACE) || (ch == CH_TAB);
    cls.digit       = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls.alpha       = lower || upper;
    cls.word        = cls.alpha || cls.digit || (ch == CH_USCORE);
    cls.ident_start = cls.alpha || (ch == CH_USCORE);
    cls.dot         = (ch == CH_DOT);
    cls.squote      = (ch == CH_SQUOTE);
    cls.dquote      = (ch == CH_DQUOTE);
    cls.bslash      = (ch == CH_BSLASH);
    cls.letter_x    = (ch == CH_LOWER_X);
    if (lower) begin
      off = ch - LOWER_BIAS;
    end else if (upper) begin
      off = ch - UPPER_BIAS;
    end else begin
      off = ch - CH_ZERO;
    end
    cls.hexval = off[5:0];
  end

endmodule

// ----- design/stl_fifo.sv -----
// Short queue of classified characters between front and back end.
module stl_fifo
  import stl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  char_class_t       push_data,
  input  logic              pop,
  output char_class_t       head,
  output logic              not_empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  char_class_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic              do_pop;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- design/stl_back.sv -----
// Back end: lexer state machine and result buffer.
module stl_back
  import stl_pkg::*;
#(
  parameter int LINE_CHARS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  char_class_t         cls,
  input  logic                q_valid,
  output logic                q_pop,
  output token_t              head,
  output logic                token_valid,
  input  logic                token_stall
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam logic [CW-1:0] LIMIT = CW'(LINE_CHARS);
  localparam int OB_DEPTH = 4;
  localparam int OB_PTR_W = 2;
  localparam int OB_CNT_W = 3;

  lex_mode_t     mode, mode_next;
  logic [31:0]   acc, acc_next;
  logic [CW-1:0] spaces, spaces_next;
  logic [CW-1:0] start, start_next;
  logic [CW-1:0] offset, offset_next;
  logic [CW-1:0] tlen, tlen_next;
  logic          dot_seen, dot_seen_next;
  logic          esc, esc_next;

  logic          emit0, emit1;
  token_t        res0, res1;

  token_t                obuf [OB_DEPTH];
  logic [OB_PTR_W-1:0]   orp, owp;
  logic [OB_CNT_W-1:0]   ocnt, ocnt_next;
  logic                  go;
  logic                  out_pop;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v != LIMIT) ? v + CW'(1) : v;
  endfunction

  function automatic token_t make_rec(input logic [2:0] kind, input logic [31:0] value,
                                      input logic [CW-1:0] sp, input logic [CW-1:0] st,
                                      input logic [CW-1:0] len);
    token_t r;
    r.kind   = kind;
    r.value  = value;
    r.spaces = FIELD_W'(sp);
    r.start  = FIELD_W'(st);
    r.length = FIELD_W'(len);
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic token_t flush_rec(input lex_mode_t m, input logic [31:0] value,
                                       input logic dt, input logic [CW-1:0] sp,
                                       input logic [CW-1:0] st, input logic [CW-1:0] len);
    logic [2:0]  kind;
    logic [31:0] v;
    kind = KIND_OTHER;
    v    = '0;
    case (m)
      MODE_IDENT:  kind = KIND_IDENT;
      MODE_ZERO:   begin kind = KIND_NUM; v = value; end
      MODE_HEX:    begin kind = KIND_HEX; v = value; end
      MODE_NUM:    begin kind = dt ? KIND_REAL : KIND_NUM; v = value; end
      MODE_CHAR:   begin kind = KIND_CHAR; v = value; end
      MODE_STRING: kind = KIND_STRING;
      default:     kind = KIND_OTHER;
    endcase
    return make_rec(kind, v, sp, st, len);
  endfunction

  // Next state and results of one character
  always_comb begin : lex_step
    logic taken;
    logic num_step;
    logic close;
    logic add_byte;
    mode_next     = mode;
    acc_next      = acc;
    spaces_next   = spaces;
    start_next    = start;
    tlen_next     = tlen;
    dot_seen_next = dot_seen;
    esc_next      = esc;
    offset_next   = cls.nul ? '0 : sat_inc(offset);
    emit0    = 1'b0;
    emit1    = 1'b0;
    res0     = '0;
    res1     = '0;
    taken    = 1'b0;
    num_step = 1'b0;
    close    = 1'b0;
    add_byte = 1'b0;

    unique case (mode)
      MODE_IDENT: taken = cls.word;
      MODE_ZERO: begin
        if (cls.letter_x) begin
          mode_next = MODE_HEX;
          taken     = 1'b1;
        end else begin
          mode_next = MODE_NUM;
          num_step  = 1'b1;
        end
      end
      MODE_NUM: num_step = 1'b1;
      MODE_HEX: begin
        if (cls.alpha || cls.digit) begin
          acc_next = {acc[27:0], 4'b0000} + 32'(cls.hexval);
          taken    = 1'b1;
        end
      end
      MODE_DOT: begin
        if (cls.digit) begin
          mode_next     = MODE_NUM;
          dot_seen_next = 1'b1;
          taken         = 1'b1;
        end
      end
      MODE_CHAR, MODE_STRING: begin
        if (!cls.nul) begin
          taken = 1'b1;
          if (esc) begin
            esc_next = 1'b0;
            add_byte = 1'b1;
          end else if (cls.bslash) begin
            esc_next = 1'b1;
          end else if ((mode == MODE_CHAR) ? cls.squote : cls.dquote) begin
            close = 1'b1;
          end else begin
            add_byte = 1'b1;
          end
        end
      end
      MODE_IDLE: ;
    endcase

    if (num_step) begin
      if (cls.digit) begin
        if (!dot_seen) begin
          acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + 32'(cls.hexval);
        end
        taken = 1'b1;
      end else if (cls.dot && !dot_seen) begin
        dot_seen_next = 1'b1;
        taken         = 1'b1;
      end
    end

    if (add_byte && mode == MODE_CHAR) begin
      acc_next = {acc[23:0], cls.ch};
    end

    if (taken) begin
      tlen_next = sat_inc(tlen);
    end

    // Report the open token when it closes or when this character does not extend it
    if (close || (!taken && mode != MODE_IDLE)) begin
      res0  = flush_rec(mode_next, acc_next, dot_seen_next, spaces_next, start_next, tlen_next);
      emit0 = 1'b1;
      mode_next     = MODE_IDLE;
      acc_next      = '0;
      spaces_next   = '0;
      tlen_next     = '0;
      dot_seen_next = 1'b0;
      esc_next      = 1'b0;
    end

    // Handle the character from an idle lexer
    if (!taken) begin
      if (cls.blank) begin
        spaces_next = sat_inc(spaces_next);
      end else if (cls.nul) begin
        if (!emit0) begin
          res0  = make_rec(KIND_END, '0, spaces_next, offset, '0);
          emit0 = 1'b1;
        end else begin
          res1  = make_rec(KIND_END, '0, spaces_next, offset, '0);
          emit1 = 1'b1;
        end
        mode_next     = MODE_IDLE;
        acc_next      = '0;
        spaces_next   = '0;
        start_next    = '0;
        tlen_next     = '0;
        dot_seen_next = 1'b0;
        esc_next      = 1'b0;
      end else begin
        start_next    = offset;
        tlen_next     = CW'(1);
        acc_next      = '0;
        dot_seen_next = 1'b0;
        esc_next      = 1'b0;
        if (cls.ident_start) begin
          mode_next = MODE_IDENT;
        end else if (cls.digit && cls.hexval == '0) begin
          mode_next = MODE_ZERO;
        end else if (cls.digit) begin
          mode_next = MODE_NUM;
          acc_next  = 32'(cls.hexval);
        end else if (cls.dot) begin
          mode_next = MODE_DOT;
        end else if (cls.squote) begin
          mode_next = MODE_CHAR;
        end else if (cls.dquote) begin
          mode_next = MODE_STRING;
        end else begin
          // Single-byte token: report at once and drop back to idle
          if (!emit0) begin
            res0  = make_rec(KIND_OTHER, '0, spaces_next, offset, CW'(1));
            emit0 = 1'b1;
          end else begin
            res1  = make_rec(KIND_OTHER, '0, spaces_next, offset, CW'(1));
            emit1 = 1'b1;
          end
          mode_next   = MODE_IDLE;
          spaces_next = '0;
          tlen_next   = '0;
        end
      end
    end

    if (emit1) begin
      res1.last = 1'b1;
    end else if (emit0) begin
      res0.last = 1'b1;
    end
  end

  // Handshake and result buffer control
  always_comb begin : ctl
    go          = q_valid && (ocnt <= OB_CNT_W'(OB_DEPTH - 2));
    q_pop       = go;
    token_valid = (ocnt != '0);
    out_pop     = token_valid && !token_stall;
    head        = obuf[orp];
    ocnt_next   = ocnt + OB_CNT_W'(go && emit0) + OB_CNT_W'(go && emit1)
                - OB_CNT_W'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (go && emit0) begin
      obuf[owp] <= res0;
    end
    if (go && emit1) begin
      obuf[owp + OB_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      acc      <= '0;
      spaces   <= '0;
      start    <= '0;
      offset   <= '0;
      tlen     <= '0;
      dot_seen <= 1'b0;
      esc      <= 1'b0;
      orp      <= '0;
      owp      <= '0;
      ocnt     <= '0;
    end else begin
      if (go) begin
        mode     <= mode_next;
        acc      <= acc_next;
        spaces   <= spaces_next;
        start    <= start_next;
        offset   <= offset_next;
        tlen     <= tlen_next;
        dot_seen <= dot_seen_next;
        esc      <= esc_next;
        owp      <= owp + OB_PTR_W'(emit0) + OB_PTR_W'(emit1);
      end
      if (out_pop) begin
        orp <= orp + OB_PTR_W'(1);
      end
      ocnt <= ocnt_next;
    end
  end

endmodule

// ----- design/script_token_lexer.sv -----
// Top level of the script token lexer: front end, character queue, back end.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  ch      | in        | ch_valid / ch_stall     | ch
//  token   | out       | token_valid / token_stall | token_kind, token_value, space_count,
//          |           |                         | token_start, token_length, last
//
// One character per cycle enters while ch_stall is low; one result transaction per cycle
// leaves while token_stall is low. A character that closes one token and emits another
// yields two transactions. Characters pass through the queue, results through the buffer.
// Reset is synchronous; the block takes characters in the first cycle after it.
// A stalled output lets three or four results collect in the four-entry result buffer, then
// the lexer holds, then the four-entry character queue fills and ch_stall rises.
module script_token_lexer
  import stl_pkg::*;
#(
  parameter int LINE_CHARS = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic               [7:0]  ch,
  input  logic                      ch_valid,
  output logic                      ch_stall,
  output logic               [2:0]  token_kind,
  output logic signed        [31:0] token_value,
  output logic        [FIELD_W-1:0] space_count,
  output logic        [FIELD_W-1:0] token_start,
  output logic        [FIELD_W-1:0] token_length,
  output logic                      last,
  output logic                      token_valid,
  input  logic                      token_stall
);

  char_class_t       cls_in;
  char_class_t       cls_head;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;
  token_t            head;

  stl_front u_front (
    .ch       (ch),
    .ch_valid (ch_valid),
    .ch_stall (ch_stall),
    .q_full   (q_full),
    .push     (push),
    .cls      (cls_in)
  );

  stl_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls_in),
    .pop       (q_pop),
    .head      (cls_head),
    .not_empty (q_valid),
    .full      (q_full),
    .count     (q_count)
  );

  stl_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cls         (cls_head),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .head        (head),
    .token_valid (token_valid),
    .token_stall (token_stall)
  );

  assign token_kind   = head.kind;
  assign token_value  = $signed(head.value);
  assign space_count  = head.spaces;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last         = head.last;

  // An accepted character sits in the queue at the next edge
  assert property (@(posedge clk) disable iff (rst)
    (ch_valid && !ch_stall) |=> (q_count != '0))
    else $error("accepted character missing from queue");

  // No result is offered right after reset
  assert property (@(posedge clk) rst |=> !token_valid)
    else $error("result offered after reset");

  // A line end always closes the results of its character and has no length
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind == KIND_END) |-> (last && token_length == '0))
    else $error("end token without last flag or with length");

endmodule

// ----- tb/script_token_lexer_checker.sv -----
// Checker for the script token lexer: predicts tokens per character and compares results.
`timescale 1ns / 1ps

module script_token_lexer_checker
  import stl_pkg::*;
#(
  parameter int LINE_CHARS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               ch_valid,
  input  logic               ch_stall,
  input  logic [2:0]         token_kind,
  input  logic signed [31:0] token_value,
  input  logic [FIELD_W-1:0] space_count,
  input  logic [FIELD_W-1:0] token_start,
  input  logic [FIELD_W-1:0] token_length,
  input  logic               last,
  input  logic               token_valid,
  input  logic               token_stall,
  output int                 mismatches,
  output int                 outstanding
);

  lex_mode_t   mode;
  logic [31:0] acc;
  int          blanks;
  int          tok_start;
  int          line_pos;
  int          tok_len;
  bit          seen_dot;
  bit          escaped;
  int          fail_tally;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit word_ch(input logic [7:0] c);
    return c == CH_USCORE || letter_ch(c) || digit_ch(c);
  endfunction

  function automatic int bump(input int v);
    return (v < LINE_CHARS) ? v + 1 : v;
  endfunction

  task automatic report(input logic [2:0] kind, input logic [31:0] value);
    token_t t;
    t.kind   = kind;
    t.value  = value;
    t.spaces = blanks[FIELD_W-1:0];
    t.start  = tok_start[FIELD_W-1:0];
    t.length = tok_len[FIELD_W-1:0];
    t.last   = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic drop_token();
    mode     = MODE_IDLE;
    acc      = '0;
    blanks   = 0;
    tok_len  = 0;
    seen_dot = 1'b0;
    escaped  = 1'b0;
  endtask

  task automatic line_reset();
    drop_token();
    tok_start = 0;
    line_pos  = 0;
  endtask

  task automatic close_token();
    logic [2:0]  kind;
    logic [31:0] value;
    value = '0;
    case (mode)
      MODE_IDENT:  kind = KIND_IDENT;
      MODE_ZERO:   begin kind = KIND_NUM; value = acc; end
      MODE_HEX:    begin kind = KIND_HEX; value = acc; end
      MODE_NUM:    begin kind = seen_dot ? KIND_REAL : KIND_NUM; value = acc; end
      MODE_CHAR:   begin kind = KIND_CHAR; value = acc; end
      MODE_STRING: kind = KIND_STRING;
      default:     kind = KIND_OTHER;
    endcase
    report(kind, value);
    drop_token();
  endtask

  task automatic open_token(input lex_mode_t m, input int pos);
    mode      = m;
    tok_start = pos;
    tok_len   = 1;
    acc       = '0;
    seen_dot  = 1'b0;
    escaped   = 1'b0;
  endtask

  // Try to extend the open token with c; taken is low when c ends it.
  task automatic absorb(input logic [7:0] c, output bit taken);
    bit grow;
    bit fold;
    taken = 1'b1;
    grow  = 1'b1;
    fold  = 1'b0;
    case (mode)
      MODE_IDENT: if (!word_ch(c)) taken = 1'b0;
      MODE_ZERO, MODE_NUM: begin
        if (mode == MODE_ZERO && c == CH_LOWER_X) begin
          mode = MODE_HEX;
        end else begin
          mode = MODE_NUM;
          if (digit_ch(c)) begin
            if (!seen_dot) acc = acc * 10 + (c - CH_ZERO);
          end else if (c == CH_DOT && !seen_dot) begin
            seen_dot = 1'b1;
          end else begin
            taken = 1'b0;
          end
        end
      end
      MODE_HEX: begin
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) acc = acc * 16 + (c - LOWER_BIAS);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) acc = acc * 16 + (c - UPPER_BIAS);
        else if (digit_ch(c)) acc = acc * 16 + (c - CH_ZERO);
        else taken = 1'b0;
      end
      MODE_DOT: begin
        if (!digit_ch(c)) begin
          taken = 1'b0;
        end else begin
          mode     = MODE_NUM;
          seen_dot = 1'b1;
        end
      end
      MODE_CHAR, MODE_STRING: begin
        grow = 1'b0;
        if (c == CH_NUL) begin
          taken = 1'b0;
        end else begin
          tok_len = bump(tok_len);
          if (escaped) begin
            escaped = 1'b0;
            fold    = 1'b1;
          end else if (c == CH_BSLASH) begin
            escaped = 1'b1;
          end else if (c == ((mode == MODE_CHAR) ? CH_SQUOTE : CH_DQUOTE)) begin
            close_token();
          end else begin
            fold = 1'b1;
          end
          if (fold && mode == MODE_CHAR) acc = (acc << 8) + c;
        end
      end
      default: taken = 1'b0;
    endcase
    if (taken && grow) tok_len = bump(tok_len);
  endtask

  task automatic begin_token(input logic [7:0] c, input int pos);
    if (c == CH_SPACE || c == CH_TAB) begin
      blanks = bump(blanks);
    end else if (c == CH_NUL) begin
      tok_start = pos;
      tok_len   = 0;
      report(KIND_END, '0);
      line_reset();
    end else if (c == CH_USCORE || letter_ch(c)) begin
      open_token(MODE_IDENT, pos);
    end else if (c == CH_ZERO) begin
      open_token(MODE_ZERO, pos);
    end else if (digit_ch(c)) begin
      open_token(MODE_NUM, pos);
      acc = 32'(c - CH_ZERO);
    end else if (c == CH_DOT) begin
      open_token(MODE_DOT, pos);
    end else if (c == CH_SQUOTE) begin
      open_token(MODE_CHAR, pos);
    end else if (c == CH_DQUOTE) begin
      open_token(MODE_STRING, pos);
    end else begin
      open_token(MODE_DOT, pos);
      close_token();
    end
  endtask

  task automatic predict_char(input logic [7:0] c);
    int pos;
    bit taken;
    pos   = line_pos;
    taken = 1'b0;
    step_tokens.delete();
    if (mode != MODE_IDLE) begin
      absorb(c, taken);
      if (!taken) close_token();
    end
    if (!taken) begin_token(c, pos);
    if (c != CH_NUL) line_pos = bump(pos);
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      $display("%0t: token %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_token();
    token_t got;
    token_t want;
    bit     bad;
    got = '{token_kind, token_value, space_count, token_start, token_length, last};
    bad = 1'b0;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token expected none, got kind %0d value %0d start %0d",
               $time, got.kind, got.value, got.start);
      fail_tally++;
    end else begin
      want = expected_tokens.pop_front();
      field_check("kind", want.kind, got.kind, bad);
      field_check("value", want.value, got.value, bad);
      field_check("space_count", want.spaces, got.spaces, bad);
      field_check("start", want.start, got.start, bad);
      field_check("length", want.length, got.length, bad);
      field_check("last", want.last, got.last, bad);
      if (bad) fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_reset();
      expected_tokens.delete();
      fail_tally = 0;
    end else begin
      if (token_valid && !token_stall) check_token();
      if (ch_valid && !ch_stall) predict_char(ch);
    end
    mismatches  <= fail_tally;
    outstanding <= expected_tokens.size();
  end

endmodule

// ----- tb/tb_script_token_lexer.sv -----
// Testbench top for the script token lexer: clock, reset, line stimulus and verdict.
`timescale 1ns / 1ps

module tb_script_token_lexer
  import stl_pkg::*;
();

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_ITEMS  = 350;
  localparam int LONG_LINE    = 120;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_NS   = 30_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [7:0]         ch = CH_NUL;
  logic               ch_valid = 1'b0;
  logic               ch_stall;
  logic [2:0]         token_kind;
  logic signed [31:0] token_value;
  logic [FIELD_W-1:0] space_count;
  logic [FIELD_W-1:0] token_start;
  logic [FIELD_W-1:0] token_length;
  logic               last;
  logic               token_valid;
  logic               token_stall = 1'b0;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 20;
  bit rx_idle_on = 1'b1;
  bit pressure_go = 1'b0;
  int sent = 0;

  script_token_lexer uut (
    .clk          (clk),
    .rst          (rst),
    .ch           (ch),
    .ch_valid     (ch_valid),
    .ch_stall     (ch_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .space_count  (space_count),
    .token_start  (token_start),
    .token_length (token_length),
    .last         (last),
    .token_valid  (token_valid),
    .token_stall  (token_stall)
  );

  script_token_lexer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .ch           (ch),
    .ch_valid     (ch_valid),
    .ch_stall     (ch_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .space_count  (space_count),
    .token_start  (token_start),
    .token_length (token_length),
    .last         (last),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] letter_pick();
    return ($urandom_range(0, 1) == 0) ? 8'(CH_LOWER_A + $urandom_range(0, 25))
                                       : 8'(CH_UPPER_A + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] digit_pick();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] word_pick();
    case ($urandom_range(0, 3))
      0:       return digit_pick();
      1:       return CH_USCORE;
      default: return letter_pick();
    endcase
  endfunction

  function automatic logic [7:0] blank_pick();
    return ($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE;
  endfunction

  // Offer one character, with an optional idle burst ahead of it.
  task automatic send_char(input logic [7:0] c);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      ch_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    ch       <= c;
    ch_valid <= 1'b1;
    @(posedge clk);
    while (ch_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_quoted(input logic [7:0] quote);
    logic [7:0] c;
    send_char(quote);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 4) == 0) send_char(CH_BSLASH);
      c = 8'($urandom_range(1, 255));
      send_char(c);
    end
    // leave some quotes open so the line end flushes them
    if ($urandom_range(0, 7) != 0) send_char(quote);
  endtask

  task automatic send_token(input logic [2:0] kind);
    logic [7:0] c;
    case (kind)
      KIND_IDENT: begin
        send_char(($urandom_range(0, 4) == 0) ? CH_USCORE : letter_pick());
        repeat ($urandom_range(0, 6)) send_char(word_pick());
      end
      KIND_HEX: begin
        send_char(CH_ZERO);
        send_char(CH_LOWER_X);
        repeat ($urandom_range(0, 9))
          send_char(($urandom_range(0, 1) == 0) ? digit_pick() : letter_pick());
      end
      KIND_NUM: repeat ($urandom_range(1, 12)) send_char(digit_pick());
      KIND_REAL: begin
        repeat ($urandom_range(0, 4)) send_char(digit_pick());
        send_char(CH_DOT);
        repeat ($urandom_range(1, 4)) send_char(digit_pick());
      end
      KIND_CHAR:   send_quoted(CH_SQUOTE);
      KIND_STRING: send_quoted(CH_DQUOTE);
      default: begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_DOT || c == CH_SQUOTE ||
               c == CH_DQUOTE || c == CH_USCORE || (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z));
        send_char(c);
      end
    endcase
  endtask

  task automatic send_line();
    logic [2:0] kind;
    logic [7:0] c;
    if ($urandom_range(0, 19) == 0) begin
      // raw noise, a zero byte in it just ends the line early
      repeat ($urandom_range(1, 20)) begin
        c = 8'($urandom_range(0, 255));
        send_char(c);
      end
    end else begin
      repeat ($urandom_range(0, 2)) send_char(blank_pick());
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          c = 8'($urandom_range(1, 255));
          send_char(c);
        end else begin
          kind = 3'($urandom_range(KIND_IDENT, KIND_OTHER));
          send_token(kind);
        end
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 3)) send_char(blank_pick());
      end
    end
    send_char(CH_NUL);
  endtask

  initial begin
    string directed;
    directed = "0\t# 0x 7.5 .9.a'\\''\"\\\"";
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed.len(); i++) send_char(directed[i]);
    send_char(8'hFF);
    send_char(CH_NUL);

    // one longer line: a long identifier, a run of blanks, then a digit
    send_char(CH_LOWER_A);
    repeat (LONG_LINE) send_char(word_pick());
    repeat (LONG_LINE) send_char(blank_pick());
    send_char(CH_ZERO + 8'd7);
    send_char(CH_NUL);

    pressure_go = 1'b1;
    while (sent < RANDOM_ITEMS - QUIET_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 10;
        default: tx_idle_pct = 35;
      endcase
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_line();
    end

    tx_idle_pct = 0;
    rx_idle_on  = 1'b0;
    while (sent < RANDOM_ITEMS) send_line();
    ch_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("script_token_lexer regression: pass");
    else
      $display("script_token_lexer regression: fail");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold to back up the input.
  initial begin
    bit held_long;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !held_long) begin
        held_long = 1'b1;
        token_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        token_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        token_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        token_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("script_token_lexer regression: fail");
    $finish;
  end

endmodule
